FILE: src/plz_pkg.sv
// Shared types and constants for the plain LZ77 decompressor.
// Used by plz_ctrl, plz_dp and plain_lz77_decompressor; no dependencies.
package plz_pkg;

  localparam int WIN_DEPTH_DEF = 8192;
  localparam int BURST_DEF     = 64;
  localparam int CFG_AW        = 3;

  // parse phases
  localparam logic [2:0] PH_IND   = 3'd0;
  localparam logic [2:0] PH_ITEM  = 3'd1;
  localparam logic [2:0] PH_TOK2  = 3'd2;
  localparam logic [2:0] PH_NIB   = 3'd3;
  localparam logic [2:0] PH_EXT8  = 3'd4;
  localparam logic [2:0] PH_EXT16 = 3'd5;
  localparam logic [2:0] PH_EXT32 = 3'd6;

  // run status codes
  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_OFFSET   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_LENGTH   = 3'd5;
  localparam logic [2:0] ST_MISUSE   = 3'd6;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_CONT = 1'b1;

  localparam logic REG_LIMIT = 1'b0;  // register index (byte address bit 2)

  localparam logic [3:0]  NIB_ESC = 4'hF;
  localparam logic [7:0]  EXT_ESC = 8'd255;
  localparam logic [31:0] LEN_MIN = 32'd22;   // 15 + 7

  typedef struct packed {
    logic accept;
    logic parse;
    logic plan;
    logic rd;
    logic wr;
    logic emit;
  } plz_cmd_t;

  typedef struct packed {
    logic copy_start;
    logic k_zero;
    logic k_last;
    logic out_free;
  } plz_stat_t;

endpackage

FILE: src/plain_lz77_decompressor.sv
// Plain LZ77 stream decompressor, one compressed byte or one copy-continue per
// input item. An item that produces no copy is accepted, parsed and handed over
// to the output register once it is free; a match copy is accepted, parsed and
// planned, then each copied byte is read from the history RAM, then written
// back and output, at most COPY_BURST bytes per item. The history RAM needs no
// clearing pass after reset. Output_limit lies at byte address 0 of the
// register port.
// Top level: instantiates plz_ctrl and plz_dp; depends on plz_pkg.
module plain_lz77_decompressor
  import plz_pkg::*;
#(
  parameter int WINDOW_DEPTH = WIN_DEPTH_DEF,
  parameter int COPY_BURST   = BURST_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] in_byte
  input  logic              in_tuser,    // [0] cmd
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [7:0] out_byte
  output logic [4:0]        out_tuser,   // [0] out_valid, [1] copy_pending, [4:2] status
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] limit_r;
  plz_cmd_t    cmd;
  plz_stat_t   stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 32'hFFFF_FFFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_LIMIT) begin
      limit_r <= cfg_pwdata;
    end
  end

  plz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plz_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COPY_BURST   (COPY_BURST)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .limit      (limit_r),
    .in_cmd     (in_tuser),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_user   (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: src/plz_ctrl.sv
// Controller state machine of the LZ77 decompressor.
// Depends on plz_pkg; drives plz_dp through plz_cmd_t and reads plz_stat_t.
module plz_ctrl
  import plz_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  plz_stat_t stat,
  output plz_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PARSE = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_PLAN  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PARSE;
        end
      end
      S_PARSE: begin
        cmd.parse = 1'b1;
        state_nxt = stat.copy_start ? S_PLAN : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = stat.k_zero ? S_EMIT : S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (stat.out_free) begin
          cmd.wr    = 1'b1;
          state_nxt = stat.k_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one datapath command");
  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> (state_r == S_WR)) else $error("history read not followed by write");
  a_accept_parse: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.parse) else $error("accepted item not parsed");

endmodule

FILE: src/plz_dp.sv
// Datapath of the LZ77 decompressor: parser registers, copy planner,
// history RAM and output register. Depends on plz_pkg; commanded by plz_ctrl.
module plz_dp
  import plz_pkg::*;
#(
  parameter int WINDOW_DEPTH = WIN_DEPTH_DEF,
  parameter int COPY_BURST   = BURST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] limit,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [4:0]  out_user,
  input  plz_cmd_t    cmd,
  output plz_stat_t   stat
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int KW = $clog2(COPY_BURST + 1);
  localparam logic [31:0] BURST32 = 32'(COPY_BURST);

  logic [7:0]  hist [WINDOW_DEPTH];

  logic        item_cmd_r, item_last_r;
  logic [7:0]  item_byte_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] iw_r, iw_nxt;
  logic [5:0]  bl_r, bl_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic        nsv_r, nsv_nxt;
  logic [3:0]  nhi_r, nhi_nxt;
  logic [13:0] off_r, off_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] count_r;
  logic        end_r, end_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        misuse_r, res_val_r;
  logic [7:0]  res_byte_r, rd_data_r;
  logic [KW-1:0] k_r;
  logic        out_v_r, out_last_r;
  logic [7:0]  out_byte_r;
  logic [4:0]  out_user_r;

  // parse signals
  logic [31:0] fa_or, start_len, v16;
  logic [5:0]  bl_dec;
  logic [15:0] tok;
  logic        lit, start, cont, misuse_c, complete, nib_go, copy_go;
  logic [3:0]  nib_val;

  always_comb begin
    phase_nxt = phase_r; iw_nxt = iw_r; bl_nxt = bl_r; fa_nxt = fa_r;
    fbc_nxt = fbc_r; nsv_nxt = nsv_r; nhi_nxt = nhi_r; off_nxt = off_r;
    rem_nxt = rem_r; end_nxt = end_r; status_nxt = status_r;
    lit = 1'b0; start = 1'b0; cont = 1'b0; misuse_c = 1'b0; complete = 1'b1;
    nib_go = 1'b0; nib_val = '0; start_len = '0;
    fa_or  = fa_r | ({24'd0, item_byte_r} << {fbc_r, 3'b000});
    bl_dec = bl_r - 6'd1;
    tok    = {item_byte_r, fa_r[7:0]};
    v16    = fa_or;
    if (status_r != ST_RUN) begin
      // stream over: hold everything
    end else if (item_cmd_r != (rem_r != 32'd0)) begin
      misuse_c = 1'b1;
    end else if (item_cmd_r == CMD_CONT) begin
      cont = 1'b1;
    end else begin
      case (phase_r)
        PH_IND: begin
          if (fbc_r != 2'd3) begin
            fa_nxt   = fa_or;
            fbc_nxt  = fbc_r + 2'd1;
            complete = 1'b0;
          end else begin
            iw_nxt  = fa_or;
            fa_nxt  = '0;
            fbc_nxt = '0;
            if (item_last_r) begin
              status_nxt = ST_DONE;
            end else begin
              bl_nxt    = 6'd32;
              phase_nxt = PH_ITEM;
            end
          end
        end
        PH_ITEM: begin
          bl_nxt = bl_dec;
          if (!iw_r[bl_dec[4:0]]) begin
            if (count_r >= limit) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              lit = 1'b1;
              if (item_last_r || (count_r + 32'd1 >= limit)) status_nxt = ST_DONE;
              phase_nxt = (bl_dec != 6'd0) ? PH_ITEM : PH_IND;
            end
          end else begin
            fa_nxt    = {24'd0, item_byte_r};
            phase_nxt = PH_TOK2;
            complete  = 1'b0;
          end
        end
        PH_TOK2: begin
          fa_nxt  = '0;
          off_nxt = {1'b0, tok[15:3]} + 14'd1;
          if (tok[2:0] != 3'd7) begin
            start     = 1'b1;
            start_len = {29'd0, tok[2:0]} + 32'd3;
          end else if (nsv_r) begin
            nsv_nxt = 1'b0;
            nib_go  = 1'b1;
            nib_val = nhi_r;
          end else begin
            phase_nxt = PH_NIB;
            complete  = 1'b0;
          end
        end
        PH_NIB: begin
          nsv_nxt = 1'b1;
          nhi_nxt = item_byte_r[7:4];
          nib_go  = 1'b1;
          nib_val = item_byte_r[3:0];
        end
        PH_EXT8: begin
          if (item_byte_r != EXT_ESC) begin
            start     = 1'b1;
            start_len = {24'd0, item_byte_r} + 32'd25;
          end else begin
            fa_nxt    = '0;
            fbc_nxt   = '0;
            phase_nxt = PH_EXT16;
            complete  = 1'b0;
          end
        end
        PH_EXT16: begin
          if (fbc_r == 2'd0) begin
            fa_nxt   = fa_or;
            fbc_nxt  = 2'd1;
            complete = 1'b0;
          end else begin
            fa_nxt  = '0;
            fbc_nxt = '0;
            if (v16 == 32'd0) begin
              phase_nxt = PH_EXT32;
              complete  = 1'b0;
            end else if (v16 < LEN_MIN) begin
              status_nxt = ST_LENGTH;
            end else begin
              start     = 1'b1;
              start_len = v16 + 32'd3;
            end
          end
        end
        default: begin
          if (fbc_r != 2'd3) begin
            fa_nxt   = fa_or;
            fbc_nxt  = fbc_r + 2'd1;
            complete = 1'b0;
          end else begin
            fa_nxt  = '0;
            fbc_nxt = '0;
            if (fa_or < LEN_MIN) begin
              status_nxt = ST_LENGTH;
            end else begin
              start     = 1'b1;
              start_len = fa_or + 32'd3;
            end
          end
        end
      endcase
      if (nib_go) begin
        if (nib_val != NIB_ESC) begin
          start     = 1'b1;
          start_len = {28'd0, nib_val} + 32'd10;
        end else begin
          phase_nxt = PH_EXT8;
          complete  = 1'b0;
        end
      end
      if (start) begin
        if (start_len == 32'd0) begin
          status_nxt = ST_LENGTH;
        end else begin
          rem_nxt = start_len;
          end_nxt = item_last_r;
        end
      end
      if (!complete && item_last_r && status_nxt == ST_RUN) status_nxt = ST_TRUNC;
    end
    copy_go = cont || (start && start_len != 32'd0);
  end

  // copy planner: bytes for this item, errors and final status up front
  logic        off_bad;
  logic [31:0] avail, k0, rem_after;
  logic [KW-1:0] plan_k;
  logic [2:0]  plan_st, plan_ph;
  logic [31:0] plan_rem;

  always_comb begin
    off_bad   = {18'd0, off_r} > count_r;
    avail     = (count_r >= limit) ? 32'd0 : (limit - count_r);
    k0        = (rem_r < BURST32) ? rem_r : BURST32;
    rem_after = rem_r - k0;
    plan_st   = status_r;
    plan_ph   = phase_r;
    plan_rem  = rem_after;
    plan_k    = k0[KW-1:0];
    if (off_bad) begin
      plan_st  = ST_OFFSET;
      plan_rem = '0;
      plan_k   = '0;
    end else if (avail < k0) begin
      plan_st  = ST_OVERFLOW;
      plan_rem = '0;
      plan_k   = avail[KW-1:0];
    end else if (rem_after == 32'd0) begin
      if (end_r || avail == k0) plan_st = ST_DONE;
      plan_ph = (bl_r != 6'd0) ? PH_ITEM : PH_IND;
    end
  end

  logic out_free;
  assign out_free = !out_v_r || out_tready;

  assign stat.copy_start = copy_go;
  assign stat.k_zero     = (plan_k == '0);
  assign stat.k_last     = (k_r == KW'(1));
  assign stat.out_free   = out_free;

  logic [AW-1:0] rd_addr;
  assign rd_addr = count_r[AW-1:0] - off_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.parse && lit) hist[count_r[AW-1:0]] <= item_byte_r;
    if (cmd.wr)           hist[count_r[AW-1:0]] <= rd_data_r;
    if (cmd.rd)           rd_data_r <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IND; iw_r <= '0; bl_r <= '0; fa_r <= '0; fbc_r <= '0;
      nsv_r <= 1'b0; nhi_r <= '0; off_r <= '0; rem_r <= '0; count_r <= '0;
      end_r <= 1'b0; status_r <= ST_RUN; misuse_r <= 1'b0; k_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.parse) begin
        phase_r <= phase_nxt; iw_r <= iw_nxt; bl_r <= bl_nxt; fa_r <= fa_nxt;
        fbc_r <= fbc_nxt; nsv_r <= nsv_nxt; nhi_r <= nhi_nxt; off_r <= off_nxt;
        rem_r <= rem_nxt; end_r <= end_nxt; status_r <= status_nxt;
        misuse_r <= misuse_c;
        if (lit) count_r <= count_r + 32'd1;
      end
      if (cmd.plan) begin
        status_r <= plan_st;
        phase_r  <= plan_ph;
        rem_r    <= plan_rem;
        k_r      <= plan_k;
        misuse_r <= 1'b0;
      end
      if (cmd.wr) begin
        count_r <= count_r + 32'd1;
        k_r     <= k_r - KW'(1);
      end
      if (cmd.emit || cmd.wr) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd_r  <= in_cmd;
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
    if (cmd.parse) begin
      res_byte_r <= lit ? item_byte_r : 8'd0;
      res_val_r  <= lit;
    end
    if (cmd.plan) begin
      res_byte_r <= 8'd0;
      res_val_r  <= 1'b0;
    end
    if (cmd.emit) begin
      out_byte_r <= res_byte_r;
      out_last_r <= 1'b1;
      out_user_r <= {(misuse_r ? ST_MISUSE : status_r), (rem_r != 32'd0), res_val_r};
    end else if (cmd.wr) begin
      out_byte_r <= rd_data_r;
      out_last_r <= (k_r == KW'(1));
      out_user_r <= {status_r, (rem_r != 32'd0), 1'b1};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_user   = out_user_r;

  a_k_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.wr) |-> (k_r != '0)) else $error("copy step with empty burst");
  a_rem_running: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 32'd0) |-> (status_r == ST_RUN)) else $error("copy pending after end");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.wr) |-> out_free) else $error("output register overwritten");

endmodule

FILE: tb/sv/plain_lz77_decompressor_test.sv
// Self-checking bench for plain_lz77_decompressor: drives one compressed stream
// through the item port and checks every output item against a predictor.
// Depends on plz_pkg and the plain_lz77_decompressor RTL.
module plain_lz77_decompressor_test;
  import plz_pkg::*;

  localparam int HIST_MASK  = WIN_DEPTH_DEF - 1;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       lst;
    logic       pend;
    logic [2:0] st;
  } byte_res_t;

  typedef enum int {
    END_WORD, END_LITERAL, END_TRUNC, END_OFFSET, END_OVERFLOW, END_LIMIT, END_LENGTH
  } end_kind_t;

  class plz_scoreboard;
    logic [31:0] limit;
    logic [2:0]  phase;
    logic [31:0] ind_word;
    int          bits_left;
    logic [31:0] asm_word;
    int          asm_n;
    bit          nib_saved;
    logic [3:0]  nib_hi;
    logic [31:0] offset;
    logic [31:0] remaining;
    logic [31:0] count;
    logic [7:0]  hist [WIN_DEPTH_DEF];
    logic [2:0]  status;
    bit          end_after;
    logic [7:0]  obuf[$];
    byte_res_t   exp_q[$];
    int          errors;

    function void init();
      limit = '1; phase = PH_IND; ind_word = 0; bits_left = 0; asm_word = 0;
      asm_n = 0; nib_saved = 0; nib_hi = 0; offset = 0; remaining = 0; count = 0;
      status = ST_RUN; end_after = 0; errors = 0;
    endfunction

    function void put(logic [7:0] b);
      hist[count & HIST_MASK] = b;
      count++;
      obuf.push_back(b);
    endfunction

    function void finish_tok(bit last);
      if (last || count >= limit) status = ST_DONE;
      phase = (bits_left != 0) ? PH_ITEM : PH_IND;
    endfunction

    function void drain();
      while (remaining != 0 && obuf.size() < BURST_DEF) begin
        if (offset > count) begin
          status = ST_OFFSET; remaining = 0; return;
        end
        if (count >= limit) begin
          status = ST_OVERFLOW; remaining = 0; return;
        end
        put(hist[(count - offset) & HIST_MASK]);
        remaining--;
      end
      if (remaining == 0 && status == ST_RUN) finish_tok(end_after);
    endfunction

    function void start_copy(logic [31:0] len, bit last);
      if (len == 0) begin
        status = ST_LENGTH;
        return;
      end
      remaining = len;
      end_after = last;
      drain();
    endfunction

    function bit after_nib(logic [3:0] len4, bit last);
      if (len4 != NIB_ESC) begin
        start_copy({28'b0, len4} + 32'd10, last);
        return 1;
      end
      phase = PH_EXT8;
      return 0;
    endfunction

    // returns 1 when the token or word is complete
    function bit feed(logic [7:0] b, bit last);
      logic [31:0] v;
      case (phase)
        PH_IND: begin
          asm_word |= {24'b0, b} << (8 * asm_n);
          if (asm_n != 3) begin
            asm_n++;
            return 0;
          end
          ind_word = asm_word; asm_word = 0; asm_n = 0;
          if (last) begin
            status = ST_DONE;
            return 1;
          end
          bits_left = 32;
          phase = PH_ITEM;
          return 1;
        end
        PH_ITEM: begin
          bits_left--;
          if (ind_word[bits_left] == 1'b0) begin
            if (count >= limit) begin
              status = ST_OVERFLOW;
              return 1;
            end
            put(b);
            finish_tok(last);
            return 1;
          end
          asm_word = {24'b0, b};
          phase = PH_TOK2;
          return 0;
        end
        PH_TOK2: begin
          v = asm_word | ({24'b0, b} << 8);
          asm_word = 0;
          offset = (v >> 3) + 1;
          if (v[2:0] != 3'd7) begin
            start_copy({29'b0, v[2:0]} + 32'd3, last);
            return 1;
          end
          if (nib_saved) begin
            nib_saved = 0;
            return after_nib(nib_hi, last);
          end
          phase = PH_NIB;
          return 0;
        end
        PH_NIB: begin
          nib_saved = 1;
          nib_hi = b[7:4];
          return after_nib(b[3:0], last);
        end
        PH_EXT8: begin
          if (b != EXT_ESC) begin
            start_copy({24'b0, b} + 32'd25, last);
            return 1;
          end
          asm_word = 0; asm_n = 0;
          phase = PH_EXT16;
          return 0;
        end
        PH_EXT16: begin
          asm_word |= {24'b0, b} << (8 * asm_n);
          if (asm_n == 0) begin
            asm_n = 1;
            return 0;
          end
          v = asm_word; asm_word = 0; asm_n = 0;
          if (v == 0) begin
            phase = PH_EXT32;
            return 0;
          end
          if (v < LEN_MIN) begin
            status = ST_LENGTH;
            return 1;
          end
          start_copy(v + 32'd3, last);
          return 1;
        end
        default: begin
          asm_word |= {24'b0, b} << (8 * asm_n);
          if (asm_n != 3) begin
            asm_n++;
            return 0;
          end
          v = asm_word; asm_word = 0; asm_n = 0;
          if (v < LEN_MIN) begin
            status = ST_LENGTH;
            return 1;
          end
          start_copy(v + 32'd3, last);
          return 1;
        end
      endcase
    endfunction

    function void note_item(logic c, logic [7:0] b, logic last);
      logic [2:0] st;
      byte_res_t r;
      obuf.delete();
      if (status != ST_RUN) st = status;
      else if ((c == CMD_CONT) != (remaining != 0)) st = ST_MISUSE;
      else begin
        if (c == CMD_CONT) drain();
        else if (!feed(b, last) && last && status == ST_RUN) status = ST_TRUNC;
        st = status;
      end
      if (obuf.size() == 0) begin
        r = '{data: 8'd0, vld: 1'b0, lst: 1'b1, pend: remaining != 0, st: st};
        exp_q.push_back(r);
      end
      foreach (obuf[k]) begin
        r = '{data: obuf[k], vld: 1'b1, lst: k == obuf.size() - 1,
              pend: remaining != 0, st: st};
        exp_q.push_back(r);
      end
    endfunction

    function void cmp(string name, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check(logic [7:0] data, logic [4:0] user, logic lst);
      byte_res_t e;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected output item, expected none, got data %0h user %0h",
                 $time, data, user);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      cmp("out_byte", e.data, data);
      cmp("out_valid", {7'd0, e.vld}, {7'd0, user[0]});
      cmp("copy_pending", {7'd0, e.pend}, {7'd0, user[1]});
      cmp("status", {5'd0, e.st}, {5'd0, user[4:2]});
      cmp("run_last", {7'd0, e.lst}, {7'd0, lst});
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [7:0]  out_tdata;
  logic [4:0]  out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  plz_scoreboard sb;
  int          idle_cycles;
  int          burst_left;
  logic [15:0] tok;
  logic [31:0] ext_len;
  logic [31:0] ind_gen;
  end_kind_t   end_kind;

  plain_lz77_decompressor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  initial begin : rx_stall
    int rx_cyc;
    rx_cyc = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (rx_cyc >= 3000 && rx_cyc < 3400) out_tready <= 0;
      else case ((rx_cyc / 97) % 3)
        0: out_tready <= 1;
        1: out_tready <= 1'($urandom_range(1, 0));
        default: out_tready <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser, out_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("[plain_lz77_decompressor] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic c, logic [7:0] b, logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(60, 1);
      gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser  <= c;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_item(c, b, l);
    @(negedge clk);
  endtask

  // feed one byte, then drain any copy it starts
  task automatic feed_b(logic [7:0] b, logic l = 0);
    send_item(CMD_FEED, b, l);
    while (sb.remaining != 0) send_item(CMD_CONT, 8'($urandom), 0);
  endtask

  // hold off until every expected item has come back
  task automatic settle();
    in_tvalid <= 0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] val);
    settle();
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_paddr   <= {REG_LIMIT, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    sb.limit = val;
  endtask

  // pick the next item from what the parser is waiting for
  task automatic gen_item();
    int lim;
    if (sb.remaining != 0) begin
      if ($urandom_range(19, 0) == 0)
        send_item(CMD_FEED, 8'($urandom), 1'($urandom_range(1, 0)));
      else send_item(CMD_CONT, 8'($urandom), 0);
      return;
    end
    if ($urandom_range(29, 0) == 0) begin
      send_item(CMD_CONT, 8'($urandom), 1'($urandom_range(1, 0)));
      return;
    end
    case (sb.phase)
      PH_IND: begin
        if (sb.asm_n == 0) ind_gen = ($urandom_range(1, 0) != 0) ? $urandom : $urandom & $urandom;
        send_item(CMD_FEED, 8'(ind_gen >> (8 * sb.asm_n)), 0);
      end
      PH_ITEM: begin
        if (sb.ind_word[sb.bits_left - 1] == 1'b0) send_item(CMD_FEED, 8'($urandom), 0);
        else begin
          lim = (sb.count >= WIN_DEPTH_DEF) ? WIN_DEPTH_DEF : int'(sb.count);
          case ($urandom_range(3, 0))
            0: tok[15:3] = '0;
            1: tok[15:3] = 13'(lim - 1);
            default: tok[15:3] = 13'($urandom_range(lim, 1) - 1);
          endcase
          tok[2:0] = ($urandom_range(9, 0) < 7) ? 3'($urandom_range(6, 0)) : 3'd7;
          send_item(CMD_FEED, tok[7:0], 0);
        end
      end
      PH_TOK2: send_item(CMD_FEED, tok[15:8], 0);
      PH_NIB: send_item(CMD_FEED, {4'($urandom),
                        ($urandom_range(6, 0) == 0) ? NIB_ESC : 4'($urandom_range(14, 0))}, 0);
      PH_EXT8: send_item(CMD_FEED, ($urandom_range(4, 0) == 0) ? EXT_ESC
                                                                : 8'($urandom_range(254, 0)), 0);
      PH_EXT16: begin
        if (sb.asm_n == 0) ext_len = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(200, 22);
        send_item(CMD_FEED, 8'(ext_len >> (8 * sb.asm_n)), 0);
      end
      default: begin
        if (sb.asm_n == 0) ext_len = $urandom_range(200, 22);
        send_item(CMD_FEED, 8'(ext_len >> (8 * sb.asm_n)), 0);
      end
    endcase
  endtask

  task automatic send_word(logic [31:0] w, logic l = 0);
    for (int k = 0; k < 4; k++) send_item(CMD_FEED, 8'(w >> (8 * k)), (k == 3) ? l : 1'b0);
  endtask

  task automatic finish_stream();
    int sub;
    case (end_kind)
      END_WORD: send_word($urandom, 1);
      END_LITERAL: begin
        send_word(32'h0);
        send_item(CMD_FEED, 8'($urandom), 1);
      end
      END_TRUNC: begin
        send_item(CMD_FEED, 8'($urandom), 0);
        send_item(CMD_FEED, 8'($urandom), 1);
      end
      END_OFFSET: begin
        send_word(32'h8000_0000);
        tok = {13'(sb.count), 3'd2};
        feed_b(tok[7:0]);
        feed_b(tok[15:8]);
      end
      END_OVERFLOW, END_LIMIT: begin
        write_limit(sb.count + ((end_kind == END_OVERFLOW) ? 32'd5 : 32'd9));
        send_word(32'h8000_0000);
        feed_b(8'h06);
        feed_b(8'h00);
      end
      default: begin
        // walk the length escapes down to a bad 16- or 32-bit field
        sub = $urandom_range(2, 0);
        send_word(32'hFFFF_FFFF);
        while (sb.status == ST_RUN) begin
          case (sb.phase)
            PH_IND:   feed_b(8'hFF);
            PH_ITEM:  feed_b(8'h07);
            PH_TOK2:  feed_b(8'h00);
            PH_NIB:   feed_b(8'h0F);
            PH_EXT8:  feed_b(EXT_ESC);
            PH_EXT16: feed_b((sub == 0 && sb.asm_n == 0) ? 8'd5 : 8'd0);
            default:  feed_b(8'(((sub == 1) ? 32'd21 : 32'hFFFF_FFFD) >> (8 * sb.asm_n)));
          endcase
        end
      end
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] long_len;
    int off;
    sb = new();
    sb.init();
    rst_n = 0; burst_left = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = 0; in_tlast = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    end_kind = end_kind_t'($urandom_range(END_LENGTH, END_WORD));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    write_limit(32'hFFFF_FFFF);
    // literal, short match, literal, escaped long match, max offset, nibble
    send_word(32'h5C00_0000);
    feed_b(8'h00);
    feed_b(8'h00); feed_b(8'h00);
    feed_b(8'hFF);
    feed_b(8'h07); feed_b(8'h00);
    feed_b(8'h3F);
    feed_b(EXT_ESC);
    // keep the output short of the window when a bad offset must stay reachable
    long_len = (end_kind == END_OFFSET) ? 16'd100 : 16'd9000;
    feed_b(long_len[7:0]); feed_b(long_len[15:8]);
    off = (sb.count >= WIN_DEPTH_DEF) ? WIN_DEPTH_DEF : int'(sb.count);
    tok = {13'(off - 1), 3'd7};
    feed_b(tok[7:0]); feed_b(tok[15:8]);
    send_item(CMD_CONT, 8'h00, 0);
    feed_b(8'h07); feed_b(8'h00); feed_b(8'hE0);

    for (int i = 0; i < 50; i++) begin
      if (i == 15) write_limit($urandom_range(32'hFFFF_FFFE, 32'h0010_0000));
      if (i == 30) settle();
      if (i == 40) write_limit(32'hFFFF_FFFF);
      gen_item();
    end
    while (!(sb.phase == PH_IND && sb.asm_n == 0 && sb.remaining == 0) && sb.status == ST_RUN)
      gen_item();
    if (end_kind == END_OFFSET && sb.count >= WIN_DEPTH_DEF - 1) end_kind = END_LENGTH;
    if (sb.status == ST_RUN) finish_stream();

    // everything after the end returns the stored status
    repeat (4) send_item(1'($urandom_range(1, 0)), 8'($urandom), 1'($urandom_range(1, 0)));
    write_limit(32'h0);
    repeat (3) send_item(1'($urandom_range(1, 0)), 8'($urandom), 1'($urandom_range(1, 0)));
    settle();
    if (sb.errors == 0) begin
      $display("[plain_lz77_decompressor] OK");
    end else begin
      $display("[plain_lz77_decompressor] ERROR");
    end
    $finish;
  end

endmodule
